FILE: hdl/ptsp_pkg.sv
// ----------------------------------------------------------------------------
// ptsp_pkg
// shared types and codes for the paletted texture stream parser
// ----------------------------------------------------------------------------
package ptsp_pkg;

  // result kind codes
  localparam logic [1:0] KIND_COLOR = 2'd0;
  localparam logic [1:0] KIND_SIZE  = 2'd1;
  localparam logic [1:0] KIND_PIXEL = 2'd2;

  // parser phase, one-hot
  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_PALETTE = 5'b00010,
    PH_WIDTH   = 5'b00100,
    PH_HEIGHT  = 5'b01000,
    PH_PIXELS  = 5'b10000
  } phase_t;

  // byte handed from the input register to the parser core
  typedef struct packed {
    logic       fire;
    logic [7:0] data_byte;
  } step_t;

  // one result transaction
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] color;
    logic [7:0]  pixel_index;
    logic [8:0]  image_width;
    logic [8:0]  image_height;
    logic        has_alpha;
    logic        last;
  } res_t;

endpackage

FILE: hdl/paletted_texture_stream_parser.sv
// a byte waits in the input register, and its result is loaded into the result register that drives the outputs
// one byte per cycle while the result register can load, results drain at one per cycle
// bytes that give no result (header, width, partial entries) still load the result register, leaving it empty
// the pace is set by the input register feeding the result register directly
// reset: rst_n synchronous active low, parser returns to header byte zero
// ----------------------------------------------------------------------------
// paletted_texture_stream_parser
// byte-serial parser emitting palette colors, image size and pixel indices
// ----------------------------------------------------------------------------
module paletted_texture_stream_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [31:0] out_color,
  output logic [7:0]  out_pixel_index,
  output logic [8:0]  out_image_width,
  output logic [8:0]  out_image_height,
  output logic        out_has_alpha,
  output logic        out_last
);
  import ptsp_pkg::*;

  // the input register advances whenever the result register has room
  logic  can_load;
  step_t step;
  logic  res_valid;
  res_t  res;
  res_t  out_res;

  ptsp_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .advance      (can_load),
    .step         (step)
  );

  // state update and result assembly for the byte in the input register
  ptsp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register, loaded on every consumed byte (empty when it has no result)
  ptsp_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step.fire),
    .res_valid (res_valid),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_kind         = out_res.kind;
  assign out_color        = out_res.color;
  assign out_pixel_index  = out_res.pixel_index;
  assign out_image_width  = out_res.image_width;
  assign out_image_height = out_res.image_height;
  assign out_has_alpha    = out_res.has_alpha;
  assign out_last         = out_res.last;

endmodule

FILE: hdl/ptsp_in_stage.sv
// ----------------------------------------------------------------------------
// ptsp_in_stage
// input register: holds one byte until the parser core can consume it
// ----------------------------------------------------------------------------
module ptsp_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_data_byte,
  input  logic            advance,
  output ptsp_pkg::step_t step
);
  import ptsp_pkg::*;

  logic       valid_r;
  logic [7:0] data_r;

  assign in_ready       = !valid_r || advance;
  assign step.fire      = valid_r && advance;
  assign step.data_byte = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data_byte;
    end
  end

endmodule

FILE: hdl/ptsp_core.sv
// ----------------------------------------------------------------------------
// ptsp_core
// parser state and per-byte result assembly
// ----------------------------------------------------------------------------
module ptsp_core (
  input  logic            clk,
  input  logic            rst_n,
  input  ptsp_pkg::step_t step,
  output logic            res_valid,
  output ptsp_pkg::res_t  res
);
  import ptsp_pkg::*;

  phase_t      phase_r,         phase_nxt;
  logic [2:0]  byte_pos_r,      byte_pos_nxt;
  logic        alpha_mode_r,    alpha_mode_nxt;
  logic [7:0]  entries_left_r,  entries_left_nxt;
  logic [23:0] entry_bytes_r,   entry_bytes_nxt;
  logic        alpha_nonzero_r, alpha_nonzero_nxt;
  logic [8:0]  width_hold_r,    width_hold_nxt;
  logic [16:0] pixels_left_r,   pixels_left_nxt;

  logic [7:0]  b;
  logic [23:0] shifted;
  logic [8:0]  w;
  logic [8:0]  h;
  logic [17:0] area;
  logic [16:0] pix_dec;

  function automatic logic [8:0] size_of(input logic [7:0] v);
    return (v == 8'd0) ? 9'd256 : {1'b0, v};
  endfunction

  assign b       = step.data_byte;
  assign shifted = {entry_bytes_r[15:0], b};
  assign w       = (width_hold_r == 9'd0) ? 9'd256 : width_hold_r;
  assign h       = size_of(b);
  assign area    = {9'd0, w} * {9'd0, h};
  assign pix_dec = pixels_left_r - 17'd1;

  always_comb begin
    phase_nxt         = phase_r;
    byte_pos_nxt      = byte_pos_r;
    alpha_mode_nxt    = alpha_mode_r;
    entries_left_nxt  = entries_left_r;
    entry_bytes_nxt   = entry_bytes_r;
    alpha_nonzero_nxt = alpha_nonzero_r;
    width_hold_nxt    = width_hold_r;
    pixels_left_nxt   = pixels_left_r;
    res_valid         = 1'b0;
    res               = '0;

    unique case (phase_r)
      PH_HEADER: begin
        if (byte_pos_r == 3'd3) begin
          alpha_mode_nxt = (b == 8'd1);
          byte_pos_nxt   = 3'd4;
        end else if (byte_pos_r[2]) begin
          entries_left_nxt  = b;
          byte_pos_nxt      = 3'd0;
          entry_bytes_nxt   = '0;
          alpha_nonzero_nxt = 1'b0;
          phase_nxt         = (b == 8'd0) ? PH_WIDTH : PH_PALETTE;
        end else begin
          byte_pos_nxt = byte_pos_r + 3'd1;
        end
      end
      PH_PALETTE: begin
        if (alpha_mode_r && byte_pos_r == 3'd0) begin
          alpha_nonzero_nxt = (b != 8'd0);
          byte_pos_nxt      = 3'd1;
        end else if (byte_pos_r < (alpha_mode_r ? 3'd3 : 3'd2)) begin
          entry_bytes_nxt = shifted;
          byte_pos_nxt    = byte_pos_r + 3'd1;
        end else begin
          res_valid = 1'b1;
          res.kind  = KIND_COLOR;
          if (!alpha_mode_r) begin
            res.color = {8'd0, shifted};
          end else if (alpha_nonzero_r) begin
            res.color = {8'hFF, shifted};
          end
          // entry done
          byte_pos_nxt      = 3'd0;
          entry_bytes_nxt   = '0;
          alpha_nonzero_nxt = 1'b0;
          entries_left_nxt  = entries_left_r - 8'd1;
          if (entries_left_r == 8'd1) begin
            phase_nxt = PH_WIDTH;
          end
        end
      end
      PH_WIDTH: begin
        width_hold_nxt = h;
        phase_nxt      = PH_HEIGHT;
      end
      PH_HEIGHT: begin
        res_valid        = 1'b1;
        res.kind         = KIND_SIZE;
        res.image_width  = w;
        res.image_height = h;
        res.has_alpha    = alpha_mode_r;
        pixels_left_nxt  = area[16:0];
        phase_nxt        = PH_PIXELS;
        if (area[16:0] == 17'd0) begin
          phase_nxt         = PH_HEADER;
          byte_pos_nxt      = '0;
          alpha_mode_nxt    = 1'b0;
          entries_left_nxt  = '0;
          entry_bytes_nxt   = '0;
          alpha_nonzero_nxt = 1'b0;
          width_hold_nxt    = '0;
          pixels_left_nxt   = '0;
        end
      end
      PH_PIXELS: begin
        res_valid       = 1'b1;
        res.kind        = KIND_PIXEL;
        res.pixel_index = b;
        pixels_left_nxt = pix_dec;
        if (pix_dec == 17'd0) begin
          // end of image: rearm for the next file
          res.last          = 1'b1;
          phase_nxt         = PH_HEADER;
          byte_pos_nxt      = '0;
          alpha_mode_nxt    = 1'b0;
          entries_left_nxt  = '0;
          entry_bytes_nxt   = '0;
          alpha_nonzero_nxt = 1'b0;
          width_hold_nxt    = '0;
        end
      end
      default: begin
        phase_nxt         = PH_HEADER;
        byte_pos_nxt      = '0;
        alpha_mode_nxt    = 1'b0;
        entries_left_nxt  = '0;
        entry_bytes_nxt   = '0;
        alpha_nonzero_nxt = 1'b0;
        width_hold_nxt    = '0;
        pixels_left_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_HEADER;
      byte_pos_r      <= '0;
      alpha_mode_r    <= 1'b0;
      entries_left_r  <= '0;
      entry_bytes_r   <= '0;
      alpha_nonzero_r <= 1'b0;
      width_hold_r    <= '0;
      pixels_left_r   <= '0;
    end else if (step.fire) begin
      phase_r         <= phase_nxt;
      byte_pos_r      <= byte_pos_nxt;
      alpha_mode_r    <= alpha_mode_nxt;
      entries_left_r  <= entries_left_nxt;
      entry_bytes_r   <= entry_bytes_nxt;
      alpha_nonzero_r <= alpha_nonzero_nxt;
      width_hold_r    <= width_hold_nxt;
      pixels_left_r   <= pixels_left_nxt;
    end
  end

`ifndef ASSERT_OFF
  // a pixel phase always has pixels still to come
  assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PIXELS |-> pixels_left_r != 17'd0)
    else $error("pixel phase with no pixels left");

  // the last pixel rearms the parser at header byte zero
  assert property (@(posedge clk) disable iff (!rst_n)
    step.fire && res_valid && res.last |=>
      phase_r == PH_HEADER && byte_pos_r == 3'd0 && !alpha_mode_r)
    else $error("parser not rearmed after last pixel");

  // at the start of a palette entry without alpha, the entry count is nonzero or the entry bytes are clear
  assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PALETTE && byte_pos_r == 3'd0 && !alpha_mode_r |->
      entries_left_r != 8'd0 || entry_bytes_r == 24'd0)
    else $error("palette entry assembly out of step");
`endif

endmodule

FILE: hdl/ptsp_out_stage.sv
// ----------------------------------------------------------------------------
// ptsp_out_stage
// result register: holds one result transaction until it is taken
// ----------------------------------------------------------------------------
module ptsp_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  logic           res_valid,
  input  ptsp_pkg::res_t res,
  output logic           can_load,
  output logic           out_valid,
  input  logic           out_ready,
  output ptsp_pkg::res_t out_res
);
  import ptsp_pkg::*;

  logic valid_r;
  res_t res_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= res_valid;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      res_r <= res;
    end
  end

endmodule
